### sv/fbfv_pkg.sv
// ----------------------------------------------------------------------------
// fbfv_pkg
// Shared types, phase and status codes, and the byte-wide CRC-32 update for
// the font blob frame validator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfv_pkg;

  // Parse phases
  localparam logic [4:0] PH_LEAD    = 5'd0;
  localparam logic [4:0] PH_START   = 5'd1;
  localparam logic [4:0] PH_FLEN0   = 5'd2;
  localparam logic [4:0] PH_FLEN1   = 5'd3;
  localparam logic [4:0] PH_FNAME   = 5'd4;
  localparam logic [4:0] PH_SEP1    = 5'd5;
  localparam logic [4:0] PH_SLEN0   = 5'd6;
  localparam logic [4:0] PH_SLEN1   = 5'd7;
  localparam logic [4:0] PH_SNAME   = 5'd8;
  localparam logic [4:0] PH_SEP2    = 5'd9;
  localparam logic [4:0] PH_BOLD    = 5'd10;
  localparam logic [4:0] PH_ITAL    = 5'd11;
  localparam logic [4:0] PH_SEP3    = 5'd12;
  localparam logic [4:0] PH_PLAIN   = 5'd13;
  localparam logic [4:0] PH_PACKED  = 5'd14;
  localparam logic [4:0] PH_DSTART  = 5'd15;
  localparam logic [4:0] PH_PAYLOAD = 5'd16;
  localparam logic [4:0] PH_SEP4    = 5'd17;
  localparam logic [4:0] PH_CRC     = 5'd18;
  localparam logic [4:0] PH_END     = 5'd19;
  localparam logic [4:0] PH_DONE    = 5'd20;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_SEP   = 3'd3;
  localparam logic [2:0] ST_BAD_CRC   = 3'd4;
  localparam logic [2:0] ST_BAD_END   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_FONT_START    = 2'd0;
  localparam logic [1:0] REG_FIELD_END     = 2'd1;
  localparam logic [1:0] REG_PAYLOAD_START = 2'd2;
  localparam logic [1:0] REG_FONT_END      = 2'd3;

  localparam logic [7:0]  LEAD_BYTE = 8'h00;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  typedef struct packed {
    logic [7:0] font_start;
    logic [7:0] field_end;
    logic [7:0] payload_start;
    logic [7:0] font_end;
  } markers_t;

  typedef struct packed {
    logic        frame_ok;
    logic [2:0]  status_code;
    logic [15:0] family_length;
    logic [15:0] style_length;
    logic [7:0]  bold_byte;
    logic [7:0]  italic_byte;
    logic [31:0] uncompressed_size;
    logic [31:0] compressed_size;
  } result_t;

  // Reflected CRC-32, one byte; flattens to an XOR network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Replace one byte lane of a 32-bit word
  function automatic logic [31:0] put_byte(input logic [31:0] w,
                                           input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0: r[7:0]   = b;
      2'd1: r[15:8]  = b;
      2'd2: r[23:16] = b;
      default: r[31:24] = b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/fbfv_cfg_regs.sv
// ----------------------------------------------------------------------------
// fbfv_cfg_regs
// Marker byte registers, written through the plain configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfv_cfg_regs
  import fbfv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output markers_t        markers
);

  // Load reset markers, then take writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      markers.font_start    <= 8'd167;
      markers.field_end     <= 8'd201;
      markers.payload_start <= 8'd200;
      markers.font_end      <= 8'd122;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FONT_START:    markers.font_start    <= cfg_data;
        REG_FIELD_END:     markers.field_end     <= cfg_data;
        REG_PAYLOAD_START: markers.payload_start <= cfg_data;
        REG_FONT_END:      markers.font_end      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/fbfv_parser.sv
// ----------------------------------------------------------------------------
// fbfv_parser
// Frame parser: phase sequencer, field capture and running CRC. Updates on
// every byte transfer and emits one result on the last byte of a blob.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfv_parser
  import fbfv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire markers_t   markers,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            res_valid,
  output result_t         res
);

  logic [4:0]  phase, phase_next;
  logic [31:0] field_counter, field_counter_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] stored_crc, stored_crc_next;
  logic [2:0]  first_error, first_error_next;
  logic [15:0] fam_name_len, fam_name_len_next;
  logic [15:0] sty_name_len, sty_name_len_next;
  logic [7:0]  bold, bold_next;
  logic [7:0]  italic, italic_next;
  logic [31:0] plain_size, plain_size_next;
  logic [31:0] packed_size, packed_size_next;
  logic [31:0] cnt_inc, cnt_dec;
  logic [2:0]  status;

  assign cnt_inc = field_counter + 32'd1;
  assign cnt_dec = field_counter - 32'd1;

  // Next-state for one byte
  always_comb begin
    phase_next         = phase;
    field_counter_next = field_counter;
    running_crc_next   = running_crc;
    stored_crc_next    = stored_crc;
    first_error_next   = first_error;
    fam_name_len_next  = fam_name_len;
    sty_name_len_next  = sty_name_len;
    bold_next          = bold;
    italic_next        = italic;
    plain_size_next    = plain_size;
    packed_size_next   = packed_size;

    if (first_error == ST_OK && phase != PH_DONE) begin
      if (phase <= PH_SEP4) begin
        running_crc_next = crc_byte(running_crc, data_byte);
      end
      case (phase)
        PH_LEAD: begin
          if (data_byte == LEAD_BYTE) phase_next = PH_START;
          else first_error_next = ST_BAD_START;
        end
        PH_START: begin
          if (data_byte == markers.font_start) phase_next = PH_FLEN0;
          else first_error_next = ST_BAD_START;
        end
        PH_FLEN0: begin
          fam_name_len_next = {8'd0, data_byte};
          phase_next        = PH_FLEN1;
        end
        PH_FLEN1: begin
          fam_name_len_next  = {data_byte, fam_name_len[7:0]};
          field_counter_next = {16'd0, data_byte, fam_name_len[7:0]};
          phase_next = ({data_byte, fam_name_len[7:0]} != 16'd0) ? PH_FNAME : PH_SEP1;
        end
        PH_FNAME: begin
          field_counter_next = cnt_dec;
          if (cnt_dec == 32'd0) phase_next = PH_SEP1;
        end
        PH_SEP1: begin
          if (data_byte == markers.field_end) phase_next = PH_SLEN0;
          else first_error_next = ST_BAD_SEP;
        end
        PH_SLEN0: begin
          sty_name_len_next = {8'd0, data_byte};
          phase_next        = PH_SLEN1;
        end
        PH_SLEN1: begin
          sty_name_len_next  = {data_byte, sty_name_len[7:0]};
          field_counter_next = {16'd0, data_byte, sty_name_len[7:0]};
          phase_next = ({data_byte, sty_name_len[7:0]} != 16'd0) ? PH_SNAME : PH_SEP2;
        end
        PH_SNAME: begin
          field_counter_next = cnt_dec;
          if (cnt_dec == 32'd0) phase_next = PH_SEP2;
        end
        PH_SEP2: begin
          if (data_byte == markers.field_end) phase_next = PH_BOLD;
          else first_error_next = ST_BAD_SEP;
        end
        PH_BOLD: begin
          bold_next  = data_byte;
          phase_next = PH_ITAL;
        end
        PH_ITAL: begin
          italic_next = data_byte;
          phase_next  = PH_SEP3;
        end
        PH_SEP3: begin
          field_counter_next = 32'd0;
          if (data_byte == markers.field_end) phase_next = PH_PLAIN;
          else first_error_next = ST_BAD_SEP;
        end
        PH_PLAIN: begin
          plain_size_next    = put_byte(plain_size, field_counter[1:0], data_byte);
          field_counter_next = cnt_inc;
          if (field_counter[1:0] == 2'd3) begin
            field_counter_next = 32'd0;
            phase_next         = PH_PACKED;
          end
        end
        PH_PACKED: begin
          packed_size_next   = put_byte(packed_size, field_counter[1:0], data_byte);
          field_counter_next = cnt_inc;
          if (field_counter[1:0] == 2'd3) begin
            field_counter_next = 32'd0;
            phase_next         = PH_DSTART;
          end
        end
        PH_DSTART: begin
          field_counter_next = packed_size;
          if (data_byte == markers.payload_start) begin
            phase_next = (packed_size != 32'd0) ? PH_PAYLOAD : PH_SEP4;
          end else begin
            first_error_next = ST_BAD_SEP;
          end
        end
        PH_PAYLOAD: begin
          field_counter_next = cnt_dec;
          if (cnt_dec == 32'd0) phase_next = PH_SEP4;
        end
        PH_SEP4: begin
          field_counter_next = 32'd0;
          if (data_byte == markers.field_end) phase_next = PH_CRC;
          else first_error_next = ST_BAD_SEP;
        end
        PH_CRC: begin
          stored_crc_next    = put_byte(stored_crc, field_counter[1:0], data_byte);
          field_counter_next = cnt_inc;
          if (field_counter[1:0] == 2'd3) begin
            field_counter_next = 32'd0;
            if (put_byte(stored_crc, field_counter[1:0], data_byte) != ~running_crc)
              first_error_next = ST_BAD_CRC;
            else
              phase_next = PH_END;
          end
        end
        PH_END: begin
          if (data_byte == markers.font_end) phase_next = PH_DONE;
          else first_error_next = ST_BAD_END;
        end
        default: ;
      endcase
    end
  end

  // Final status: an unfinished frame with no error is truncated
  always_comb begin
    status = first_error_next;
    if (first_error_next == ST_OK && phase_next != PH_DONE) status = ST_TRUNC;
  end

  assign res_valid               = take && last_byte;
  assign res.frame_ok            = (status == ST_OK);
  assign res.status_code         = status;
  assign res.family_length       = fam_name_len_next;
  assign res.style_length        = sty_name_len_next;
  assign res.bold_byte           = bold_next;
  assign res.italic_byte         = italic_next;
  assign res.uncompressed_size   = plain_size_next;
  assign res.compressed_size     = packed_size_next;

  // Advance on each transfer; clear for the next blob after the last byte
  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      phase         <= PH_LEAD;
      field_counter <= 32'd0;
      running_crc   <= CRC_INIT;
      stored_crc    <= 32'd0;
      first_error   <= ST_OK;
      fam_name_len  <= 16'd0;
      sty_name_len  <= 16'd0;
      bold          <= 8'd0;
      italic        <= 8'd0;
      plain_size    <= 32'd0;
      packed_size   <= 32'd0;
    end else if (take) begin
      phase         <= phase_next;
      field_counter <= field_counter_next;
      running_crc   <= running_crc_next;
      stored_crc    <= stored_crc_next;
      first_error   <= first_error_next;
      fam_name_len  <= fam_name_len_next;
      sty_name_len  <= sty_name_len_next;
      bold          <= bold_next;
      italic        <= italic_next;
      plain_size    <= plain_size_next;
      packed_size   <= packed_size_next;
    end
  end

endmodule

`default_nettype wire

### sv/fbfv_out_stage.sv
// ----------------------------------------------------------------------------
// fbfv_out_stage
// Result register: holds one finished result until its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfv_out_stage
  import fbfv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  input  wire logic    out_ready,
  output logic         out_valid,
  output result_t      res_out
);

  // Valid flag: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: capture on load, hold otherwise
  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

### sv/font_blob_frame_validator.sv
// The result is registered and appears in the cycle after the transfer of a blob's last byte.
// Takes one byte per cycle while in_ready is high; the byte-wide CRC and phase logic are combinational.
// Only a last byte can stall, and only while the result register holds an untaken result.
// Reset (rst, synchronous, active high) restores the marker defaults, clears the
// parser to expect the leading zero byte and empties the result register.
// ----------------------------------------------------------------------------
// font_blob_frame_validator
// Streaming frame check of a serialized font blob with CRC-32 over the frame up to the stored CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module font_blob_frame_validator
  import fbfv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             frame_ok,
  output logic [2:0]       status_code,
  output logic [15:0]      family_length,
  output logic [15:0]      style_length,
  output logic [7:0]       bold_byte,
  output logic [7:0]       italic_byte,
  output logic [31:0]      uncompressed_size,
  output logic [31:0]      compressed_size
);

  markers_t markers;
  result_t  res, res_q;
  logic     res_valid;
  logic     take;

  // Stall only a last byte whose result has nowhere to go
  assign in_ready = !out_valid || out_ready || !last_byte;
  assign take     = in_valid && in_ready;

  fbfv_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .markers      (markers)
  );

  fbfv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .markers   (markers),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  fbfv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q)
  );

  assign frame_ok          = res_q.frame_ok;
  assign status_code       = res_q.status_code;
  assign family_length     = res_q.family_length;
  assign style_length      = res_q.style_length;
  assign bold_byte         = res_q.bold_byte;
  assign italic_byte       = res_q.italic_byte;
  assign uncompressed_size = res_q.uncompressed_size;
  assign compressed_size   = res_q.compressed_size;

endmodule

`default_nettype wire

### sv/fbfv_checker.sv
// ----------------------------------------------------------------------------
// fbfv_checker
// Port-level checks of the frame validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfv_checker
  import fbfv_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       last_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       frame_ok,
  input wire logic [2:0] status_code
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_code) && $stable(frame_ok))
    else $error("result changed while stalled");

  // Deliver a result in the cycle after the last byte transfer
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("no result after last byte");

  // Never stall a byte that does not end a blob
  a_mid_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !last_byte |-> in_ready)
    else $error("non-final byte stalled");

  // Keep frame_ok consistent with the status code
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_ok == (status_code == ST_OK))
    else $error("frame_ok disagrees with status");

  // Keep the status code within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status_code <= ST_BAD_END)
    else $error("undefined status code");

endmodule

bind font_blob_frame_validator fbfv_checker u_fbfv_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_ok    (frame_ok),
  .status_code (status_code)
);

`default_nettype wire
